FILE: rtl/core/igi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// igi_pkg
// Shared types and constants of the inverse gamma interpolator: beat
// layouts, command and region codes, and the microcode control word.
// ----------------------------------------------------------------------------
package igi_pkg;

    // default geometry
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int FRACTION_BITS_DEF = 8;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // region codes
    localparam logic [1:0] REGION_BELOW  = 2'd0;
    localparam logic [1:0] REGION_ABOVE  = 2'd1;
    localparam logic [1:0] REGION_FLAT   = 2'd2;
    localparam logic [1:0] REGION_INTERP = 2'd3;

    // input beat
    typedef struct packed {
        logic       command;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
        logic [7:0] level;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [7:0]  channel;
        logic [15:0] position_fixed;
        logic [1:0]  region;
    } t_out_beat;

    // microprogram step index
    typedef logic [3:0] t_step;

    // table read address source
    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_ONE,
        ADDR_LAST,
        ADDR_NEXT
    } t_addr_sel;

    // datapath action of one step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH_H,
        OP_BELOW,
        OP_ABOVE,
        OP_SEARCH,
        OP_PREP,
        OP_DIV,
        OP_FINISH,
        OP_EMIT
    } t_op;

    // jump condition
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_QUERY,
        COND_BELOW,
        COND_ABOVE,
        COND_SEARCH,
        COND_FLAT,
        COND_DIV,
        COND_OUT_BUSY
    } t_cond;

    // one microcode word
    typedef struct packed {
        logic      accept;
        t_addr_sel addr_sel;
        t_op       op;
        t_cond     cond;
        t_step     target;
        t_step     next;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic query_in;
        logic below;
        logic above;
        logic search_more;
        logic flat;
        logic div_more;
        logic out_busy;
    } t_flags;

endpackage : igi_pkg
`default_nettype wire

FILE: rtl/core/igi_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// igi_seq
// Microcode sequencer: a step counter addresses a small read-only program,
// each word drives the datapath and picks the next step by a condition.
// ----------------------------------------------------------------------------
module igi_seq
    import igi_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_ctrl       o_ctrl
);

    // program steps
    localparam t_step STEP_IDLE       = 4'd0;
    localparam t_step STEP_RD_FIRST   = 4'd1;
    localparam t_step STEP_TEST_FIRST = 4'd2;
    localparam t_step STEP_TEST_LAST  = 4'd3;
    localparam t_step STEP_SEARCH     = 4'd4;
    localparam t_step STEP_PREP       = 4'd5;
    localparam t_step STEP_DIV        = 4'd6;
    localparam t_step STEP_FINISH     = 4'd7;
    localparam t_step STEP_OUT        = 4'd8;

    // control store
    function automatic t_ctrl f_rom(input t_step step);
        t_ctrl w;
        w = '{accept: 1'b0, addr_sel: ADDR_ZERO, op: OP_NONE, cond: COND_NEVER,
              target: STEP_IDLE, next: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.op     = OP_LATCH_H;
                w.cond   = COND_NO_QUERY;
                w.target = STEP_IDLE;
                w.next   = STEP_RD_FIRST;
            end
            STEP_RD_FIRST: begin
                w.addr_sel = ADDR_ZERO;
                w.next     = STEP_TEST_FIRST;
            end
            STEP_TEST_FIRST: begin
                w.addr_sel = ADDR_LAST;
                w.op       = OP_BELOW;
                w.cond     = COND_BELOW;
                w.target   = STEP_OUT;
                w.next     = STEP_TEST_LAST;
            end
            STEP_TEST_LAST: begin
                w.addr_sel = ADDR_ONE;
                w.op       = OP_ABOVE;
                w.cond     = COND_ABOVE;
                w.target   = STEP_OUT;
                w.next     = STEP_SEARCH;
            end
            STEP_SEARCH: begin
                w.addr_sel = ADDR_NEXT;
                w.op       = OP_SEARCH;
                w.cond     = COND_SEARCH;
                w.target   = STEP_SEARCH;
                w.next     = STEP_PREP;
            end
            STEP_PREP: begin
                w.op     = OP_PREP;
                w.cond   = COND_FLAT;
                w.target = STEP_OUT;
                w.next   = STEP_DIV;
            end
            STEP_DIV: begin
                w.op     = OP_DIV;
                w.cond   = COND_DIV;
                w.target = STEP_DIV;
                w.next   = STEP_FINISH;
            end
            STEP_FINISH: begin
                w.op   = OP_FINISH;
                w.next = STEP_OUT;
            end
            STEP_OUT: begin
                w.op     = OP_EMIT;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_OUT;
                w.next   = STEP_IDLE;
            end
            default: begin
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    t_step r_step;
    t_step n_step;
    logic  w_jump;

    assign o_ctrl = f_rom(r_step);

    // condition select
    always_comb begin
        case (o_ctrl.cond)
            COND_NEVER:    w_jump = 1'b0;
            COND_NO_QUERY: w_jump = !i_flags.query_in;
            COND_BELOW:    w_jump = i_flags.below;
            COND_ABOVE:    w_jump = i_flags.above;
            COND_SEARCH:   w_jump = i_flags.search_more;
            COND_FLAT:     w_jump = i_flags.flat;
            COND_DIV:      w_jump = i_flags.div_more;
            COND_OUT_BUSY: w_jump = i_flags.out_busy;
            default:       w_jump = 1'b0;
        endcase
        n_step = w_jump ? o_ctrl.target : o_ctrl.next;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule : igi_seq
`default_nettype wire

FILE: rtl/core/inverse_gamma_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// Load beat: taken when idle, written to the table at the accepting edge.
// Query beat: at or below the first entry gives the below result, at or above
//   the last the above result, else a one-entry-per-cycle search and a
//   bit-per-cycle divider interpolate; next beat taken in the cycle after the
//   result register loads, which waits while the output stalls.
// Reset: sequencer returns to idle and output valid clears; table not cleared.
// ----------------------------------------------------------------------------
// inverse_gamma_interpolator
// Holds a gamma table and answers the inverse position of a level by linear
// search and linear interpolation, under a microcoded sequencer.
// ----------------------------------------------------------------------------
module inverse_gamma_interpolator
    import igi_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int LAST = TABLE_ENTRIES - 1;
    localparam int FB   = FRACTION_BITS;
    localparam int PW   = (IW + FB + 1 > 17) ? IW + FB + 1 : 17;
    localparam int CHW  = (IW + 1 > 9) ? IW + 1 : 9;
    localparam int CW   = $clog2(FB + 1);
    localparam int POS_LAST_INT = LAST * (2 ** FB);
    localparam logic [7:0]  CHAN_LAST_SAT = 8'((LAST > 255) ? 255 : LAST);
    localparam logic [15:0] POS_LAST_SAT  =
        16'((POS_LAST_INT > 65535) ? 65535 : POS_LAST_INT);
    localparam logic [PW-1:0]  POS_LAST_W  = PW'(LAST) << FB;
    localparam logic [CHW-1:0] CHAN_LAST_W = CHW'(LAST);

    t_ctrl  w_ctrl;
    t_flags w_flags;

    // table and read port
    logic [7:0]    r_table [TABLE_ENTRIES];
    logic [7:0]    r_rd;
    logic [IW-1:0] w_rd_addr;
    logic [IW:0]   w_next2;
    logic          w_wr_en;

    // datapath registers
    logic [7:0]    r_h;
    logic [7:0]    r_lo;
    logic [7:0]    r_hi;
    logic [IW-1:0] r_i;
    logic [7:0]    r_den;
    logic [7:0]    r_rem;
    logic [FB:0]   r_q;
    logic          r_round;
    logic [CW-1:0] r_cnt;
    t_out_beat     r_res;
    t_out_beat     r_out;
    logic          r_out_valid;
    logic          n_out_valid;

    logic          w_in_take;
    logic [7:0]    w_num_raw;
    logic [7:0]    w_den;
    logic [7:0]    w_num;
    logic [8:0]    w_rem2;
    logic          w_sub;
    logic [PW-1:0] w_i_pos;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_pos_c;
    logic [CHW-1:0] w_chan;
    logic [CHW-1:0] w_chan_c;
    logic [15:0]   w_flat_pos;
    logic [7:0]    w_flat_chan;

    // sequencer
    igi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    assign o_in_ready = w_ctrl.accept;
    assign w_in_take  = i_in_valid && w_ctrl.accept;
    assign w_wr_en    = w_in_take && (i_in_beat.command == CMD_LOAD) &&
                        (32'(i_in_beat.entry_index) < TABLE_ENTRIES);

    // status back to the sequencer
    always_comb begin
        w_flags.query_in    = i_in_valid && (i_in_beat.command == CMD_QUERY);
        w_flags.below       = r_h <= r_rd;
        w_flags.above       = r_h >= r_rd;
        w_flags.search_more = (r_rd < r_h) && (r_i != IW'(LAST - 1));
        w_flags.flat        = r_hi == r_lo;
        w_flags.div_more    = r_cnt != CW'(1);
        w_flags.out_busy    = r_out_valid && !i_out_ready;
    end

    // read address select, next address saturates at the last entry
    assign w_next2 = {1'b0, r_i} + (IW + 1)'(2);
    always_comb begin
        case (w_ctrl.addr_sel)
            ADDR_ZERO: w_rd_addr = '0;
            ADDR_ONE:  w_rd_addr = IW'(1);
            ADDR_LAST: w_rd_addr = IW'(LAST);
            ADDR_NEXT: w_rd_addr = (w_next2 > (IW + 1)'(LAST)) ? IW'(LAST)
                                                               : w_next2[IW-1:0];
            default:   w_rd_addr = '0;
        endcase
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[IW'(i_in_beat.entry_index)] <= i_in_beat.entry_value;
        end
        r_rd <= r_table[w_rd_addr];
    end

    // segment operands, numerator clamped to the divisor
    always_comb begin
        w_num_raw = (r_h > r_lo) ? r_h - r_lo : 8'd0;
        w_den     = (r_hi > r_lo) ? r_hi - r_lo : 8'd1;
        w_num     = (w_num_raw > w_den) ? w_den : w_num_raw;
    end

    // restoring divide step
    assign w_rem2 = {r_rem, 1'b0};
    assign w_sub  = w_rem2 >= {1'b0, r_den};

    // fixed point and channel results with clamp and field saturation
    always_comb begin
        w_i_pos     = PW'(r_i) << FB;
        w_pos       = w_i_pos + PW'(r_q);
        w_pos_c     = (w_pos > POS_LAST_W) ? POS_LAST_W : w_pos;
        w_chan      = CHW'(r_i) + CHW'(r_round);
        w_chan_c    = (w_chan > CHAN_LAST_W) ? CHAN_LAST_W : w_chan;
        w_flat_pos  = (w_i_pos > PW'(16'hFFFF)) ? 16'hFFFF : w_i_pos[15:0];
        w_flat_chan = (CHW'(r_i) > CHW'(255)) ? 8'd255 : 8'(r_i);
    end

    // datapath actions
    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            OP_LATCH_H: begin
                if (w_in_take) begin
                    r_h <= i_in_beat.level;
                end
            end
            OP_BELOW: begin
                r_lo  <= r_rd;
                r_res <= '{channel: 8'd0, position_fixed: 16'd0,
                           region: REGION_BELOW};
            end
            OP_ABOVE: begin
                r_i   <= '0;
                r_res <= '{channel: CHAN_LAST_SAT, position_fixed: POS_LAST_SAT,
                           region: REGION_ABOVE};
            end
            OP_SEARCH: begin
                r_hi <= r_rd;
                if (w_flags.search_more) begin
                    r_i  <= r_i + IW'(1);
                    r_lo <= r_rd;
                end
            end
            OP_PREP: begin
                r_den   <= w_den;
                r_rem   <= (w_num == w_den) ? 8'd0 : w_num;
                r_q     <= (FB + 1)'(w_num == w_den);
                r_round <= {w_num, 1'b0} >= {1'b0, w_den};
                r_cnt   <= CW'(FB);
                r_res   <= '{channel: w_flat_chan, position_fixed: w_flat_pos,
                             region: REGION_FLAT};
            end
            OP_DIV: begin
                r_q   <= {r_q[FB-1:0], w_sub};
                r_rem <= w_sub ? 8'(w_rem2 - {1'b0, r_den}) : r_rem << 1;
                r_cnt <= r_cnt - CW'(1);
            end
            OP_FINISH: begin
                r_res.channel        <= (w_chan_c > CHW'(255)) ? 8'd255
                                                               : w_chan_c[7:0];
                r_res.position_fixed <= (w_pos_c > PW'(16'hFFFF)) ? 16'hFFFF
                                                                  : w_pos_c[15:0];
                r_res.region         <= REGION_INTERP;
            end
            OP_EMIT: begin
                if (!w_flags.out_busy) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctrl.op == OP_EMIT && !w_flags.out_busy) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule : inverse_gamma_interpolator
`default_nettype wire

FILE: rtl/core/igi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// igi_checker
// Port-level checks of the inverse gamma interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module igi_checker
    import igi_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_beat  i_in_beat,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_beat o_out_beat
);

    // a result beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat dropped or changed while stalled");

    // a query beat occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_beat.command == CMD_QUERY |=> !o_in_ready)
        else $error("input taken right after a query beat");

    // at or below the first entry the channel and position are zero
    a_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.region == REGION_BELOW |->
        o_out_beat.channel == 8'd0 && o_out_beat.position_fixed == 16'd0)
        else $error("nonzero position below first entry");

    // a flat segment gives a whole position unless saturated
    a_flat_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.region == REGION_FLAT &&
        o_out_beat.position_fixed != 16'hFFFF |->
        o_out_beat.position_fixed[FRACTION_BITS-1:0] == '0)
        else $error("fraction bits set on flat segment");

endmodule : igi_checker

bind inverse_gamma_interpolator igi_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_igi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);
`default_nettype wire
